>>> sv/hacd_pkg.sv
// ----------------------------------------------------------------------------
// Hi-res artifact color decode package
// Shared types, constants and the pixel color decode function.
// ----------------------------------------------------------------------------
package hacd_pkg;

   // Number of graphics bytes in one scanline.
   localparam int LINE_BYTES = 40;
   // Width of the byte position counter within a line.
   localparam int POS_W = 7;
   // Pixels carried by one graphics byte.
   localparam int BYTE_PIXELS = 7;

   localparam logic [POS_W-1:0] LINE_BYTES_P = POS_W'(LINE_BYTES);

   // Decode actions taken from the three-pixel history.
   localparam logic [1:0] ACT_BLACK    = 2'd0;
   localparam logic [1:0] ACT_SAME     = 2'd1;
   localparam logic [1:0] ACT_OPPOSITE = 2'd2;
   localparam logic [1:0] ACT_WHITE    = 2'd3;

   // Hue selectors into the palette table.
   localparam logic [1:0] SEL_BLACK = 2'd0;
   localparam logic [1:0] SEL_EVEN  = 2'd1;
   localparam logic [1:0] SEL_ODD   = 2'd2;
   localparam logic [1:0] SEL_WHITE = 2'd3;

   // History pattern to action: 010 own parity, 101 opposite, 11x/x11 white.
   localparam logic [1:0] DECODE_TAB [8] = '{
      ACT_BLACK, ACT_BLACK, ACT_SAME, ACT_WHITE,
      ACT_BLACK, ACT_OPPOSITE, ACT_WHITE, ACT_WHITE
   };

   // Palette: selector by palette group.
   localparam logic [2:0] HUE_TAB [4][2] = '{
      '{3'd0, 3'd4}, '{3'd2, 3'd6}, '{3'd1, 3'd5}, '{3'd3, 3'd7}
   };

   // One accepted input transaction.
   typedef struct packed {
      logic [7:0] hgr_byte;
      logic       restart;
   } hgr_item_type;

   // One decoded pixel result.
   typedef struct packed {
      logic [7:0] pixel_value;
      logic [8:0] pixel_column;
      logic       item_last;
      logic       line_end;
   } pixel_result_type;

   // Returns the shader code (hue * 32) + 16 for a history pattern.
   function automatic logic [7:0] pixel_code(input logic [2:0] hist,
                                             input logic       odd,
                                             input logic       group);
      logic [1:0] act;
      logic [1:0] sel;
      logic [2:0] hue;
      act = DECODE_TAB[hist];
      case (act)
         ACT_BLACK:    sel = SEL_BLACK;
         ACT_SAME:     sel = odd ? SEL_ODD : SEL_EVEN;
         ACT_OPPOSITE: sel = odd ? SEL_EVEN : SEL_ODD;
         ACT_WHITE:    sel = SEL_WHITE;
         default:      sel = SEL_BLACK;
      endcase
      hue = HUE_TAB[sel][group];
      return {hue, 5'b10000};
   endfunction

endpackage

>>> sv/hacd_input_stage.sv
// ----------------------------------------------------------------------------
// Hi-res artifact color decode input stage
// Holds one graphics byte transaction until the serializer takes it.
// ----------------------------------------------------------------------------
module hacd_input_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_hgr_byte,
   input  logic                  req_restart,
   input  logic                  take,
   output logic                  item_valid,
   output hacd_pkg::hgr_item_type item
);

   logic                   valid_ff;
   logic                   valid_in;
   hacd_pkg::hgr_item_type item_ff;
   logic                   accept;

   // The register may refill in the same cycle that it is emptied.
   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.hgr_byte <= req_hgr_byte;
         item_ff.restart  <= req_restart;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> sv/hacd_pixel_serializer.sv
// ----------------------------------------------------------------------------
// Hi-res artifact color decode pixel serializer
// Shifts one pixel a cycle into the history while the output stage takes it, and decodes its color.
// ----------------------------------------------------------------------------
module hacd_pixel_serializer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_valid,
   input  hacd_pkg::hgr_item_type    item,
   output logic                      take,
   input  logic                      out_take,
   output logic                      pix_valid,
   output hacd_pkg::pixel_result_type pix
);

   logic                       busy_ff, busy_in;
   logic [6:0]                 bits_ff, bits_in;
   logic                       group_ff, group_in;
   logic [2:0]                 idx_ff, idx_in;
   logic [2:0]                 hist_ff, hist_in;
   logic [hacd_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       flush_ff, flush_in;

   logic                       step_fire;
   logic                       is_last;
   logic                       new_bit;
   logic [2:0]                 hist_next;
   logic [9:0]                 column_wide;
   logic [2:0]                 hist_base;
   logic [hacd_pkg::POS_W-1:0] pos_base;
   logic [hacd_pkg::POS_W-1:0] pos_load;
   logic [hacd_pkg::POS_W-1:0] pos_plus;
   logic [2:0]                 hist_load;

   // Current pixel step: the flush step shifts in a dark pixel.
   assign step_fire   = busy_ff && out_take;
   assign is_last     = flush_ff ? (idx_ff == 3'd7) : (idx_ff == 3'd6);
   assign new_bit     = (idx_ff == 3'd7) ? 1'b0 : bits_ff[idx_ff];
   assign hist_next   = {hist_ff[1:0], new_bit};
   assign pos_plus    = pos_ff + 1'b1;
   assign column_wide = 10'({3'b000, pos_ff}) * 10'd7 + {7'b0, idx_ff} - 10'd1;

   assign pix_valid        = step_fire;
   assign pix.pixel_column = column_wide[8:0];
   assign pix.pixel_value  = hacd_pkg::pixel_code(hist_next, column_wide[0], group_ff);
   assign pix.item_last    = is_last;
   assign pix.line_end     = flush_ff && (idx_ff == 3'd7);

   // A new byte loads when idle or as the last pixel of the current byte leaves.
   assign take = item_valid && (!busy_ff || (step_fire && is_last));

   // Line state as it stands after the current byte completes.
   always_comb begin
      if (step_fire && is_last) begin
         if (flush_ff) begin
            hist_base = 3'd0;
            pos_base  = '0;
         end else begin
            hist_base = hist_next;
            pos_base  = pos_plus;
         end
      end else begin
         hist_base = hist_ff;
         pos_base  = pos_ff;
      end
   end

   // Position and history for the byte being loaded; a restart clears both.
   always_comb begin
      if (item.restart || (pos_base >= hacd_pkg::LINE_BYTES_P)) begin
         pos_load = '0;
      end else begin
         pos_load = pos_base;
      end
      hist_load = item.restart ? 3'd0 : hist_base;
   end

   // Next state of the serializer.
   always_comb begin
      busy_in  = busy_ff;
      bits_in  = bits_ff;
      group_in = group_ff;
      idx_in   = idx_ff;
      hist_in  = hist_ff;
      pos_in   = pos_ff;
      flush_in = flush_ff;
      if (step_fire) begin
         idx_in  = idx_ff + 3'd1;
         hist_in = hist_base;
         pos_in  = pos_base;
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            hist_in = hist_next;
         end
      end
      if (take) begin
         busy_in  = 1'b1;
         bits_in  = item.hgr_byte[6:0];
         group_in = item.hgr_byte[7];
         pos_in   = pos_load;
         flush_in = ((pos_load + 1'b1) >= hacd_pkg::LINE_BYTES_P);
         // The first pixel of a line only fills the history.
         if (pos_load == '0) begin
            idx_in  = 3'd1;
            hist_in = {hist_load[1:0], item.hgr_byte[0]};
         end else begin
            idx_in  = 3'd0;
            hist_in = hist_load;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         hist_ff <= 3'd0;
         pos_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         hist_ff <= hist_in;
         pos_ff  <= pos_in;
      end
   end

   // Per-byte payload registers.
   always_ff @(posedge clock) begin
      bits_ff  <= bits_in;
      group_ff <= group_in;
      idx_ff   <= idx_in;
      flush_ff <= flush_in;
   end

   // The flush step exists only on the last byte of a line.
   a_no_flush_step : assert property (@(posedge clock) disable iff (reset)
      busy_ff && !flush_ff |-> idx_ff != 3'd7)
      else $error("flush step reached on a byte that does not end the line");

   // The position never rests at or past the end of a line.
   a_pos_range : assert property (@(posedge clock) disable iff (reset)
      pos_ff < hacd_pkg::LINE_BYTES_P)
      else $error("byte position out of line range");

   // The line end pixel is always the last of its transaction.
   a_line_end_last : assert property (@(posedge clock) disable iff (reset)
      step_fire && pix.line_end |-> pix.item_last)
      else $error("line end pixel not marked as last");

   // A byte stays in work until its last pixel has gone.
   a_busy_hold : assert property (@(posedge clock) disable iff (reset)
      step_fire && !is_last |=> busy_ff)
      else $error("serializer went idle in the middle of a byte");

endmodule

>>> sv/hacd_output_stage.sv
// ----------------------------------------------------------------------------
// Hi-res artifact color decode output stage
// Result register that holds a pixel transaction until it is taken.
// ----------------------------------------------------------------------------
module hacd_output_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pix_valid,
   input  hacd_pkg::pixel_result_type pix,
   output logic                       out_take,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_pixel_value,
   output logic [8:0]                 rsp_pixel_column,
   output logic                       rsp_item_last,
   output logic                       rsp_line_end
);

   logic                       valid_ff;
   hacd_pkg::pixel_result_type pix_ff;

   // The register takes a new pixel when empty or when its content leaves.
   assign out_take = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_take) begin
         valid_ff <= pix_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take && pix_valid) begin
         pix_ff <= pix;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pixel_value  = pix_ff.pixel_value;
   assign rsp_pixel_column = pix_ff.pixel_column;
   assign rsp_item_last    = pix_ff.item_last;
   assign rsp_line_end     = pix_ff.line_end;

endmodule

>>> sv/hires_artifact_color_decode_unit.sv
// A byte passes the input register and the serializer before its results reach
// the result register. One pixel result per cycle while rsp_stall is low; the
// first pixel of a line only fills the history, its last byte adds a flush step.
// A new byte is taken while the previous byte's pixels are still leaving.
// Reset (synchronous) empties all stages and clears history and line position.
// ----------------------------------------------------------------------------
// Hi-res artifact color decode unit
// Decodes graphics bytes into artifact color shader codes, one per pixel.
// ----------------------------------------------------------------------------
module hires_artifact_color_decode_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_hgr_byte,
   input  logic       req_restart,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_pixel_value,
   output logic [8:0] rsp_pixel_column,
   output logic       rsp_item_last,
   output logic       rsp_line_end
);

   logic                       item_valid;
   hacd_pkg::hgr_item_type     item;
   logic                       take;
   logic                       out_take;
   logic                       pix_valid;
   hacd_pkg::pixel_result_type pix;

   // Input register for one byte transaction.
   hacd_input_stage u_input (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_hgr_byte (req_hgr_byte),
      .req_restart  (req_restart),
      .take         (take),
      .item_valid   (item_valid),
      .item         (item)
   );

   // Pixel history, position and color decode.
   hacd_pixel_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .out_take   (out_take),
      .pix_valid  (pix_valid),
      .pix        (pix)
   );

   // Result register.
   hacd_output_stage u_output (
      .clock            (clock),
      .reset            (reset),
      .pix_valid        (pix_valid),
      .pix              (pix),
      .out_take         (out_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_pixel_column (rsp_pixel_column),
      .rsp_item_last    (rsp_item_last),
      .rsp_line_end     (rsp_line_end)
   );

endmodule
